### hw/rtl/mhfp_pkg.sv
`default_nettype none

package mhfp_pkg;

    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_COLON = 8'h3a;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_PRINT_LO = 8'h21;
    localparam logic [7:0] CH_PRINT_HI = 8'h7e;

    localparam int RUN_SLOTS = 3;

    typedef enum logic [2:0] {
        KIND_NAME_BYTE = 3'd0,
        KIND_NAME_END  = 3'd1,
        KIND_BODY_BYTE = 3'd2,
        KIND_FIELD_END = 3'd3,
        KIND_HDR_END   = 3'd4,
        KIND_MSG_BYTE  = 3'd5,
        KIND_ERROR     = 3'd6,
        KIND_MSG_END   = 3'd7
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE       = 3'd0,
        ERR_SPACE_NAME = 3'd1,
        ERR_BAD_NAME   = 3'd2,
        ERR_UNEXP_END  = 3'd3,
        ERR_MISSING_LF = 3'd4,
        ERR_MISSING_CR = 3'd5
    } err_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
        err_t       err;
    } result_t;

    // results caused by one input transfer, slot 0 first
    typedef struct packed {
        logic [1:0]                  count;
        result_t [RUN_SLOTS-1:0]     slot;
    } run_t;

endpackage

`default_nettype wire

### hw/rtl/mhfp_ifs.sv
`default_nettype none

interface mhfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_input;

    modport source (output valid, output data_byte, output end_of_input, input ready);
    modport sink (input valid, input data_byte, input end_of_input, output ready);
endinterface

interface mhfp_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [2:0] error_code;
    logic       last_of_run;

    modport source (output valid, output kind, output out_byte, output error_code,
                    output last_of_run, input ready);
    modport sink (input valid, input kind, input out_byte, input error_code,
                  input last_of_run, output ready);
endinterface

interface mhfp_cfg_if;
    logic valid;
    logic ready;
    logic allow_bare_lf;

    modport source (output valid, output allow_bare_lf, input ready);
    modport sink (input valid, input allow_bare_lf, output ready);
endinterface

`default_nettype wire

### hw/rtl/mhfp_front.sv
`default_nettype none

module mhfp_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    mhfp_byte_if.sink          bytes,
    mhfp_cfg_if.sink           cfg,
    input  wire logic          push_ready,
    output logic               push_valid,
    output mhfp_pkg::run_t     push_run
);
    import mhfp_pkg::*;

    typedef enum logic [3:0] {
        PH_LINE_START = 4'd0,
        PH_LS_CR      = 4'd1,
        PH_NAME       = 4'd2,
        PH_BODY       = 4'd3,
        PH_BODY_CR    = 4'd4,
        PH_BODY_CRLF  = 4'd5,
        PH_BODY_LF    = 4'd6,
        PH_MSG        = 4'd7,
        PH_ERR        = 4'd8
    } phase_t;

    typedef struct packed {
        phase_t  phase;
        logic    skip;
        logic    emit;
        result_t res;
    } step_t;

    phase_t phase_reg, phase_next;
    logic   skip_reg, skip_next;
    logic   bare_lf_reg;
    logic   accept;
    step_t  st;
    run_t   run;
    logic [1:0] cnt;

    function automatic result_t mk(input kind_t k, input logic [7:0] d, input err_t e);
        result_t r;
        r.kind = k;
        r.data = d;
        r.err  = e;
        return r;
    endfunction

    function automatic step_t name_char(input logic [7:0] b, input logic sk);
        step_t s;
        s.skip = sk;
        s.emit = 1'b1;
        if (b == CH_COLON) begin
            s.phase = PH_BODY;
            s.skip  = 1'b1;
            s.res   = mk(KIND_NAME_END, 8'd0, ERR_NONE);
        end else if (b == CH_SPACE) begin
            s.phase = PH_ERR;
            s.res   = mk(KIND_ERROR, 8'd0, ERR_SPACE_NAME);
        end else if (b >= CH_PRINT_LO && b <= CH_PRINT_HI) begin
            s.phase = PH_NAME;
            s.res   = mk(KIND_NAME_BYTE, b, ERR_NONE);
        end else begin
            s.phase = PH_ERR;
            s.res   = mk(KIND_ERROR, 8'd0, ERR_BAD_NAME);
        end
        return s;
    endfunction

    function automatic step_t line_start(input logic [7:0] b, input logic bare,
                                         input logic sk);
        step_t s;
        s = name_char(b, sk);
        if (b == CH_CR) begin
            s.phase = PH_LS_CR;
            s.skip  = sk;
            s.emit  = 1'b0;
        end else if (b == CH_LF && bare) begin
            s.phase = PH_MSG;
            s.skip  = sk;
            s.emit  = 1'b1;
            s.res   = mk(KIND_HDR_END, 8'd0, ERR_NONE);
        end
        return s;
    endfunction

    assign accept      = bytes.valid && bytes.ready;
    assign bytes.ready = push_ready;
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        phase_next = phase_reg;
        skip_next  = skip_reg;
        run        = '0;
        cnt        = 2'd0;
        st         = line_start(bytes.data_byte, bare_lf_reg, skip_reg);
        if (bytes.end_of_input) begin
            phase_next = PH_LINE_START;
            skip_next  = 1'b0;
            unique case (phase_reg)
                PH_MSG, PH_ERR:
                begin
                end
                PH_BODY_CRLF, PH_BODY_LF:
                begin
                    run.slot[cnt] = mk(KIND_FIELD_END, 8'd0, ERR_NONE);
                    cnt = cnt + 2'd1;
                    run.slot[cnt] = mk(KIND_ERROR, 8'd0, ERR_UNEXP_END);
                    cnt = cnt + 2'd1;
                end
                PH_LS_CR:
                begin
                    run.slot[cnt] = mk(KIND_ERROR, 8'd0, ERR_BAD_NAME);
                    cnt = cnt + 2'd1;
                end
                PH_BODY_CR:
                begin
                    run.slot[cnt] = mk(KIND_ERROR, 8'd0, ERR_MISSING_LF);
                    cnt = cnt + 2'd1;
                end
                default:
                begin
                    run.slot[cnt] = mk(KIND_ERROR, 8'd0, ERR_UNEXP_END);
                    cnt = cnt + 2'd1;
                end
            endcase
            run.slot[cnt] = mk(KIND_MSG_END, 8'd0, ERR_NONE);
            cnt = cnt + 2'd1;
        end else begin
            unique case (phase_reg)
                PH_LINE_START, PH_NAME:
                begin
                    if (phase_reg == PH_NAME) begin
                        st = name_char(bytes.data_byte, skip_reg);
                    end
                    phase_next = st.phase;
                    skip_next  = st.skip;
                    if (st.emit) begin
                        run.slot[cnt] = st.res;
                        cnt = cnt + 2'd1;
                    end
                end
                PH_LS_CR:
                begin
                    if (bytes.data_byte == CH_LF) begin
                        phase_next = PH_MSG;
                        run.slot[cnt] = mk(KIND_HDR_END, 8'd0, ERR_NONE);
                    end else begin
                        phase_next = PH_ERR;
                        run.slot[cnt] = mk(KIND_ERROR, 8'd0, ERR_BAD_NAME);
                    end
                    cnt = cnt + 2'd1;
                end
                PH_BODY:
                begin
                    skip_next = 1'b0;
                    if (bytes.data_byte == CH_CR) begin
                        phase_next = PH_BODY_CR;
                    end else if (bytes.data_byte == CH_LF) begin
                        if (bare_lf_reg) begin
                            phase_next = PH_BODY_LF;
                        end else begin
                            phase_next = PH_ERR;
                            run.slot[cnt] = mk(KIND_ERROR, 8'd0, ERR_MISSING_CR);
                            cnt = cnt + 2'd1;
                        end
                    end else if (!(skip_reg && bytes.data_byte == CH_SPACE)) begin
                        run.slot[cnt] = mk(KIND_BODY_BYTE, bytes.data_byte, ERR_NONE);
                        cnt = cnt + 2'd1;
                    end
                end
                PH_BODY_CR:
                begin
                    if (bytes.data_byte == CH_LF) begin
                        phase_next = PH_BODY_CRLF;
                    end else begin
                        phase_next = PH_ERR;
                        run.slot[cnt] = mk(KIND_ERROR, 8'd0, ERR_MISSING_LF);
                        cnt = cnt + 2'd1;
                    end
                end
                PH_BODY_CRLF, PH_BODY_LF:
                begin
                    if (bytes.data_byte == CH_SPACE || bytes.data_byte == CH_TAB) begin
                        // folding keeps the break in the body
                        if (phase_reg == PH_BODY_CRLF) begin
                            run.slot[cnt] = mk(KIND_BODY_BYTE, CH_CR, ERR_NONE);
                            cnt = cnt + 2'd1;
                        end
                        run.slot[cnt] = mk(KIND_BODY_BYTE, CH_LF, ERR_NONE);
                        cnt = cnt + 2'd1;
                        run.slot[cnt] = mk(KIND_BODY_BYTE, bytes.data_byte, ERR_NONE);
                        cnt = cnt + 2'd1;
                        phase_next = PH_BODY;
                    end else begin
                        run.slot[cnt] = mk(KIND_FIELD_END, 8'd0, ERR_NONE);
                        cnt = cnt + 2'd1;
                        phase_next = st.phase;
                        skip_next  = st.skip;
                        if (st.emit) begin
                            run.slot[cnt] = st.res;
                            cnt = cnt + 2'd1;
                        end
                    end
                end
                PH_MSG:
                begin
                    run.slot[cnt] = mk(KIND_MSG_BYTE, bytes.data_byte, ERR_NONE);
                    cnt = cnt + 2'd1;
                end
                default:
                begin
                    phase_next = PH_ERR;
                end
            endcase
        end
        run.count = cnt;
    end

    assign push_valid = accept && (cnt != 2'd0);
    assign push_run   = run;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg   <= PH_LINE_START;
            skip_reg    <= 1'b0;
            bare_lf_reg <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                skip_reg  <= skip_next;
            end
            if (cfg.valid && cfg.ready) begin
                bare_lf_reg <= cfg.allow_bare_lf;
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mhfp_queue.sv
`default_nettype none

module mhfp_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push_valid,
    input  mhfp_pkg::run_t      push_run,
    output logic                push_ready,
    input  wire logic           pop,
    output logic                head_valid,
    output mhfp_pkg::run_t      head
);
    import mhfp_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    run_t            mem [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && head_valid;

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_run;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CW'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CW'(1);
            end
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mhfp_back.sv
`default_nettype none

module mhfp_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          head_valid,
    input  mhfp_pkg::run_t     head,
    output logic               pop,
    mhfp_result_if.source      results
);
    import mhfp_pkg::*;

    logic       out_valid_reg;
    result_t    out_res_reg;
    logic       out_last_reg;
    logic [1:0] idx_reg;
    logic       load, is_last;

    assign load    = !out_valid_reg || results.ready;
    assign is_last = (idx_reg == head.count - 2'd1);
    assign pop     = load && head_valid && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            idx_reg       <= 2'd0;
        end else if (load) begin
            out_valid_reg <= head_valid;
            if (head_valid) begin
                idx_reg <= is_last ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load && head_valid) begin
            out_res_reg  <= head.slot[idx_reg];
            out_last_reg <= is_last;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.kind        = out_res_reg.kind;
    assign results.out_byte    = out_res_reg.data;
    assign results.error_code  = out_res_reg.err;
    assign results.last_of_run = out_last_reg;

endmodule

`default_nettype wire

### hw/rtl/mail_header_field_parser.sv
// each result is registered in the run queue and then in the output register
// throughput: one input transfer per cycle while the run queue is not full; one result
// per cycle while results.ready is high; a folded CR LF gives three results, LF two
// a run queue of QUEUE_DEPTH entries lets input run ahead of a stalled output
// reset: asynchronous active-low rst_n clears parse state, allow_bare_lf and the queue
`default_nettype none

module mail_header_field_parser #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    mhfp_byte_if.sink        bytes,
    mhfp_cfg_if.sink         cfg,
    mhfp_result_if.source    results
);
    import mhfp_pkg::*;

    logic push_valid, push_ready, pop, head_valid;
    run_t push_run, head;

    mhfp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .bytes      (bytes),
        .cfg        (cfg),
        .push_ready (push_ready),
        .push_valid (push_valid),
        .push_run   (push_run)
    );

    mhfp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_run   (push_run),
        .push_ready (push_ready),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    mhfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .results    (results)
    );

endmodule

`default_nettype wire
